>>> hdl/http_chunked_body_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Width of the chunk size accumulator.
    localparam int SIZE_BITS = 32;

    // Depth of the queue between front and back, and of the result queue.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Line end characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Parser phases.
    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_SIZE_LF = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_DATA_CR = 3'd3;
    localparam logic [2:0] PH_DATA_LF = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    // Status codes on the result.
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE = 3'd2;
    localparam logic [2:0] ST_NO_CRLF  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // One classified body byte as it travels from front to back.
    typedef struct packed {
        logic [7:0] raw;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } class_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [2:0] status;
    } result_t;

    // Classify a byte: hex digit value and line end flags.
    function automatic class_t classify(input logic [7:0] c);
        class_t r;
        r.raw     = c;
        r.is_hex  = 1'b0;
        r.hex_val = 4'd0;
        r.is_cr   = (c == CH_CR);
        r.is_lf   = (c == CH_LF);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.is_hex  = 1'b1;
            r.hex_val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // Letters a-f and A-F share their low nibble 1..6.
            r.is_hex  = 1'b1;
            r.hex_val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

>>> hdl/hcbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts body bytes, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_macros.svh"

module hcbd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_byte,
    output logic                item_valid,
    output hcbd_pkg::class_t    item,
    input  logic                item_take
);

    hcbd_pkg::class_t                  q_mem_reg [hcbd_pkg::Q_DEPTH];
    logic [hcbd_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [hcbd_pkg::Q_PTR_W-1:0]      wr_ptr_next;
    logic [hcbd_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [hcbd_pkg::Q_PTR_W-1:0]      rd_ptr_next;
    logic [hcbd_pkg::Q_CNT_W-1:0]      count_reg;
    logic [hcbd_pkg::Q_CNT_W-1:0]      count_next;
    logic                              wr_en;
    logic                              rd_en;

    // Queue status toward both sides.
    assign full       = (count_reg == hcbd_pkg::Q_CNT_W'(hcbd_pkg::Q_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            if (wr_ptr_reg == hcbd_pkg::Q_PTR_W'(hcbd_pkg::Q_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            if (rd_ptr_reg == hcbd_pkg::Q_PTR_W'(hcbd_pkg::Q_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classified byte storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem_reg[wr_ptr_reg] <= hcbd_pkg::classify(in_byte);
    end

    // Checks.
    `HCBD_ASSERT_NOW(a_front_count_bound, clk, rst_n, 1'b1,
        count_reg <= hcbd_pkg::Q_CNT_W'(hcbd_pkg::Q_DEPTH), "front queue overfilled")
    `HCBD_ASSERT_NEXT(a_front_count_step, clk, rst_n, wr_en && !rd_en,
        count_reg == $past(count_reg) + 1'b1, "front queue count missed a transfer")
    `HCBD_ASSERT_NEXT(a_front_count_drop, clk, rst_n, rd_en && !wr_en,
        count_reg == $past(count_reg) - 1'b1, "front queue count missed a take")

endmodule

>>> hdl/hcbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_back
// Runs the chunk parser on classified bytes and queues the results.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_macros.svh"

module hcbd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  hcbd_pkg::class_t    item,
    output logic                item_take,
    output logic                empty,
    input  logic                pop,
    output hcbd_pkg::result_t   head
);

    logic [2:0]                        phase_reg;
    logic [2:0]                        phase_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]    bytes_left_reg;
    logic [hcbd_pkg::SIZE_BITS-1:0]    bytes_left_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]    bytes_dec;
    logic                              digit_seen_reg;
    logic                              digit_seen_next;
    logic [2:0]                        error_code_reg;
    logic [2:0]                        error_code_next;
    hcbd_pkg::result_t                 res;

    hcbd_pkg::result_t                 oq_mem_reg [hcbd_pkg::Q_DEPTH];
    logic [hcbd_pkg::Q_PTR_W-1:0]      owr_ptr_reg;
    logic [hcbd_pkg::Q_PTR_W-1:0]      owr_ptr_next;
    logic [hcbd_pkg::Q_PTR_W-1:0]      ord_ptr_reg;
    logic [hcbd_pkg::Q_PTR_W-1:0]      ord_ptr_next;
    logic [hcbd_pkg::Q_CNT_W-1:0]      ocount_reg;
    logic [hcbd_pkg::Q_CNT_W-1:0]      ocount_next;
    logic                              o_full;
    logic                              rd_en;

    // A byte is parsed whenever one is queued and the result queue has room.
    assign o_full    = (ocount_reg == hcbd_pkg::Q_CNT_W'(hcbd_pkg::Q_DEPTH));
    assign item_take = item_valid && !o_full;
    assign empty     = (ocount_reg == '0);
    assign head      = oq_mem_reg[ord_ptr_reg];
    assign rd_en     = pop && !empty;
    assign bytes_dec = bytes_left_reg - 1'b1;

    // Parser next state and result for the byte being taken.
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        digit_seen_next = digit_seen_reg;
        error_code_next = error_code_reg;
        res             = '0;
        if (item_take)
        begin
            case (phase_reg)
                hcbd_pkg::PH_SIZE:
                begin
                    if (!digit_seen_reg && (item.is_cr || item.is_lf))
                    begin
                        // Stray line end before a size line is skipped.
                    end
                    else if (item.is_hex)
                    begin
                        if (bytes_left_reg[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            phase_next      = hcbd_pkg::PH_ERROR;
                            error_code_next = hcbd_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            bytes_left_next = {bytes_left_reg[hcbd_pkg::SIZE_BITS-5:0],
                                               item.hex_val};
                            digit_seen_next = 1'b1;
                        end
                    end
                    else if (digit_seen_reg && item.is_cr)
                    begin
                        phase_next = hcbd_pkg::PH_SIZE_LF;
                    end
                    else
                    begin
                        phase_next      = hcbd_pkg::PH_ERROR;
                        error_code_next = hcbd_pkg::ST_BAD_SIZE;
                    end
                end
                hcbd_pkg::PH_SIZE_LF:
                begin
                    if (!item.is_lf)
                    begin
                        phase_next      = hcbd_pkg::PH_ERROR;
                        error_code_next = hcbd_pkg::ST_BAD_SIZE;
                    end
                    else if (bytes_left_reg == '0)
                        phase_next = hcbd_pkg::PH_DONE;
                    else
                        phase_next = hcbd_pkg::PH_DATA;
                end
                hcbd_pkg::PH_DATA:
                begin
                    res.out_byte    = item.raw;
                    res.out_valid   = 1'b1;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                        phase_next = hcbd_pkg::PH_DATA_CR;
                end
                hcbd_pkg::PH_DATA_CR:
                begin
                    if (item.is_cr)
                        phase_next = hcbd_pkg::PH_DATA_LF;
                    else
                    begin
                        phase_next      = hcbd_pkg::PH_ERROR;
                        error_code_next = hcbd_pkg::ST_NO_CRLF;
                    end
                end
                hcbd_pkg::PH_DATA_LF:
                begin
                    if (item.is_lf)
                    begin
                        phase_next      = hcbd_pkg::PH_SIZE;
                        digit_seen_next = 1'b0;
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        phase_next      = hcbd_pkg::PH_ERROR;
                        error_code_next = hcbd_pkg::ST_NO_CRLF;
                    end
                end
                hcbd_pkg::PH_DONE:
                begin
                    // End of body reached; the byte is ignored.
                end
                default:
                begin
                    phase_next = hcbd_pkg::PH_ERROR;
                end
            endcase

            // Status follows the phase after this byte.
            if (phase_next == hcbd_pkg::PH_DONE)
                res.status = hcbd_pkg::ST_DONE;
            else if (phase_next == hcbd_pkg::PH_ERROR)
                res.status = error_code_next;
            else
                res.status = hcbd_pkg::ST_RUN;
        end
    end

    // Result queue pointers and fill count.
    always_comb
    begin
        owr_ptr_next = owr_ptr_reg;
        ord_ptr_next = ord_ptr_reg;
        ocount_next  = ocount_reg;
        if (item_take)
        begin
            if (owr_ptr_reg == hcbd_pkg::Q_PTR_W'(hcbd_pkg::Q_DEPTH - 1))
                owr_ptr_next = '0;
            else
                owr_ptr_next = owr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            if (ord_ptr_reg == hcbd_pkg::Q_PTR_W'(hcbd_pkg::Q_DEPTH - 1))
                ord_ptr_next = '0;
            else
                ord_ptr_next = ord_ptr_reg + 1'b1;
        end
        if (item_take && !rd_en)
            ocount_next = ocount_reg + 1'b1;
        else if (rd_en && !item_take)
            ocount_next = ocount_reg - 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hcbd_pkg::PH_SIZE;
            bytes_left_reg <= '0;
            digit_seen_reg <= 1'b0;
            error_code_reg <= hcbd_pkg::ST_RUN;
            owr_ptr_reg    <= '0;
            ord_ptr_reg    <= '0;
            ocount_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            digit_seen_reg <= digit_seen_next;
            error_code_reg <= error_code_next;
            owr_ptr_reg    <= owr_ptr_next;
            ord_ptr_reg    <= ord_ptr_next;
            ocount_reg     <= ocount_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (item_take)
            oq_mem_reg[owr_ptr_reg] <= res;
    end

    // Checks.
    `HCBD_ASSERT_NEXT(a_done_sticky, clk, rst_n, phase_reg == hcbd_pkg::PH_DONE,
        phase_reg == hcbd_pkg::PH_DONE, "done state was left")
    `HCBD_ASSERT_NEXT(a_error_sticky, clk, rst_n, phase_reg == hcbd_pkg::PH_ERROR,
        phase_reg == hcbd_pkg::PH_ERROR && $stable(error_code_reg),
        "error state or code changed")
    `HCBD_ASSERT_NOW(a_payload_only_in_data, clk, rst_n,
        item_take && phase_reg != hcbd_pkg::PH_DATA, !res.out_valid,
        "payload flagged outside a data phase")

endmodule

>>> hdl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Bytewise decoder for a chunked HTTP message body.
// ----------------------------------------------------------------------------
// Usage:
//   Body bytes enter on in_byte; a transfer happens at a clock edge with push
//   high and full low. Each input byte yields exactly one result, in order,
//   on out_byte, out_valid and status; the oldest result is shown while empty
//   is low and is transferred at an edge with pop high and empty low.
//   out_valid marks payload bytes; status reports running, done or the error
//   class, and done and errors hold until reset.
//   Path: a transferred byte is classified into the front queue, then parsed
//   into the result queue once that has room, and shown from then on; empty
//   falls once the result is written.
//   Throughput: one byte per cycle while the receiver keeps popping; the
//   parser update (size accumulate or payload count-down) is combinational.
//   Reset clears both queues and returns the parser to waiting for a size
//   line. When the receiver stops popping, the two-entry result queue fills,
//   the parser stops, the two-entry front queue fills, and full rises.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic [2:0]  status
);

    logic               item_valid;
    logic               item_take;
    hcbd_pkg::class_t   item;
    hcbd_pkg::result_t  head;

    // Front: input transfer, classification and queueing.
    hcbd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Back: chunk parser and result queue.
    hcbd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .head       (head)
    );

    // Result fields onto their ports.
    assign out_byte  = head.out_byte;
    assign out_valid = head.out_valid;
    assign status    = head.status;

endmodule

>>> tb/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking testbench for the bytewise chunked body decoder.
// ----------------------------------------------------------------------------
// A chunked body is built up front. It opens with a short hand-written
// section that covers stray line ends, leading zeros and line-end bytes
// inside the payload. Many well-formed chunks with random sizes, random
// digit case and random payload follow. One randomly chosen ending closes
// the body: a zero-size line, a bad size byte, a CR without LF, a size
// overflow or a missing CR LF after the data. A few further bytes then
// check that the final status holds. A scoreboard predicts every result
// from the accepted bytes and compares it with what the block returns.
// Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------

// Predicts the decoder result for each accepted byte and checks the results.
class chunk_scoreboard;

    hcbd_pkg::result_t              expected_q[$];
    logic [2:0]                     phase;
    logic [hcbd_pkg::SIZE_BITS-1:0] remaining;
    bit                             digit_seen;
    logic [2:0]                     err_code;
    int                             mismatches;

    function new();
        phase      = hcbd_pkg::PH_SIZE;
        remaining  = '0;
        digit_seen = 1'b0;
        err_code   = hcbd_pkg::ST_RUN;
        mismatches = 0;
    endfunction

    // Value of a hex digit, or -1 when the byte is not one.
    function int hex_digit(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function void enter_error(logic [2:0] code);
        phase    = hcbd_pkg::PH_ERROR;
        err_code = code;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the predicted parser by one accepted byte and queue its result.
    function void note_byte(logic [7:0] c);
        hcbd_pkg::result_t r;
        int                h;
        r = '0;
        h = hex_digit(c);
        case (phase)
            hcbd_pkg::PH_SIZE:
            begin
                if (!digit_seen && (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_LF))
                begin
                    // Stray line end ahead of a size line.
                end
                else if (h >= 0)
                begin
                    if (remaining[hcbd_pkg::SIZE_BITS-1:hcbd_pkg::SIZE_BITS-4] != '0)
                        enter_error(hcbd_pkg::ST_OVERFLOW);
                    else
                    begin
                        remaining  = {remaining[hcbd_pkg::SIZE_BITS-5:0], 4'(h)};
                        digit_seen = 1'b1;
                    end
                end
                else if (digit_seen && c == hcbd_pkg::CH_CR)
                    phase = hcbd_pkg::PH_SIZE_LF;
                else
                    enter_error(hcbd_pkg::ST_BAD_SIZE);
            end
            hcbd_pkg::PH_SIZE_LF:
            begin
                if (c != hcbd_pkg::CH_LF)
                    enter_error(hcbd_pkg::ST_BAD_SIZE);
                else if (remaining == '0)
                    phase = hcbd_pkg::PH_DONE;
                else
                    phase = hcbd_pkg::PH_DATA;
            end
            hcbd_pkg::PH_DATA:
            begin
                r.out_byte  = c;
                r.out_valid = 1'b1;
                remaining   = remaining - 1'b1;
                if (remaining == '0)
                    phase = hcbd_pkg::PH_DATA_CR;
            end
            hcbd_pkg::PH_DATA_CR:
            begin
                if (c == hcbd_pkg::CH_CR)
                    phase = hcbd_pkg::PH_DATA_LF;
                else
                    enter_error(hcbd_pkg::ST_NO_CRLF);
            end
            hcbd_pkg::PH_DATA_LF:
            begin
                if (c == hcbd_pkg::CH_LF)
                begin
                    phase      = hcbd_pkg::PH_SIZE;
                    digit_seen = 1'b0;
                    remaining  = '0;
                end
                else
                    enter_error(hcbd_pkg::ST_NO_CRLF);
            end
            hcbd_pkg::PH_DONE:
            begin
                // The body has ended; bytes are ignored.
            end
            default:
            begin
                phase = hcbd_pkg::PH_ERROR;
            end
        endcase
        if (phase == hcbd_pkg::PH_DONE)
            r.status = hcbd_pkg::ST_DONE;
        else if (phase == hcbd_pkg::PH_ERROR)
            r.status = err_code;
        else
            r.status = hcbd_pkg::ST_RUN;
        expected_q.push_back(r);
    endfunction

    // Compare one transferred result with the oldest prediction.
    function void check_result(logic [7:0] ob, logic ov, logic [2:0] st);
        hcbd_pkg::result_t e;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: unexpected result byte %02h valid %0d status %0d",
                         ob, ov, st);
            return;
        end
        e = expected_q.pop_front();
        if (e.out_byte !== ob || e.out_valid !== ov || e.status !== st)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected byte %02h valid %0d status %0d,",
                         e.out_byte, e.out_valid, e.status,
                         " got byte %02h valid %0d status %0d", ob, ov, st);
        end
    endfunction

endclass

module tb_http_chunked_body_decoder;

    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    // Ways in which the body may end.
    typedef enum int
    {
        END_ZERO_SIZE,
        END_BAD_BYTE,
        END_CR_NO_LF,
        END_OVERFLOW,
        END_NO_CRLF
    } ending_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;

    chunk_scoreboard sb;
    logic [7:0]      body_q[$];
    bit              drain_mark[int];
    bit              send_calm = 1'b0;
    bit              recv_calm = 1'b0;
    int              cycle_count = 0;

    http_chunked_body_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .status    (status)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(int nib, bit upper);
        if (nib < 10)
            return 8'(CH_ZERO + nib);
        return 8'((upper ? 8'h41 : 8'h61) + nib - 10);
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // A random byte that is neither a hex digit nor CR, and optionally not LF.
    function automatic logic [7:0] pick_non_hex(bit allow_lf);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex_char(c) || c == hcbd_pkg::CH_CR || (!allow_lf && c == hcbd_pkg::CH_LF))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_not(logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == avoid)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 16);
        if (r < 97)
            return $urandom_range(17, 64);
        return $urandom_range(100, 300);
    endfunction

    // Size line with optional stray line ends and leading zeros.
    function automatic void add_size_line(int unsigned size);
        int ndig;
        if ($urandom_range(0, 9) < 2)
            repeat ($urandom_range(1, 3))
                body_q.push_back($urandom_range(0, 1) ? hcbd_pkg::CH_CR : hcbd_pkg::CH_LF);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                body_q.push_back(CH_ZERO);
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0)
            ndig++;
        for (int k = ndig - 1; k >= 0; k--)
            body_q.push_back(hex_char((size >> (4 * k)) & 15, $urandom_range(0, 1)));
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(hcbd_pkg::CH_LF);
    endfunction

    function automatic void add_payload(int unsigned size);
        repeat (size)
            body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One of the ways to end the body, then bytes that must be ignored.
    function automatic void add_ending();
        ending_t kind;
        int      ndig;
        kind = ending_t'($urandom_range(0, 4));
        case (kind)
            END_ZERO_SIZE:
            begin
                repeat ($urandom_range(0, 2))
                    body_q.push_back(CH_ZERO);
                body_q.push_back(CH_ZERO);
                body_q.push_back(hcbd_pkg::CH_CR);
                body_q.push_back(hcbd_pkg::CH_LF);
            end
            END_BAD_BYTE:
            begin
                ndig = $urandom_range(0, 3);
                repeat (ndig)
                    body_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
                body_q.push_back(pick_non_hex(ndig != 0));
            end
            END_CR_NO_LF:
            begin
                body_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
                body_q.push_back(hcbd_pkg::CH_CR);
                body_q.push_back(pick_not(hcbd_pkg::CH_LF));
            end
            END_OVERFLOW:
            begin
                // Eight digits with a nonzero lead fill the size; a ninth overflows.
                body_q.push_back(hex_char($urandom_range(1, 15), $urandom_range(0, 1)));
                repeat (8)
                    body_q.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
            default:
            begin
                ndig = $urandom_range(1, 8);
                add_size_line(ndig);
                add_payload(ndig);
                if ($urandom_range(0, 1))
                    body_q.push_back(pick_not(hcbd_pkg::CH_CR));
                else
                begin
                    body_q.push_back(hcbd_pkg::CH_CR);
                    body_q.push_back(pick_not(hcbd_pkg::CH_LF));
                end
            end
        endcase
        add_payload($urandom_range(8, 24));
    endfunction

    // Directed opening, random chunks, then the ending.
    function automatic void build_body();
        int unsigned size;
        // Stray line ends, a size with leading zeros and a zero payload byte.
        body_q = '{hcbd_pkg::CH_CR, hcbd_pkg::CH_LF, hcbd_pkg::CH_LF, CH_ZERO, CH_ZERO,
                   8'h31, hcbd_pkg::CH_CR, hcbd_pkg::CH_LF,
                   8'h00, hcbd_pkg::CH_CR, hcbd_pkg::CH_LF};
        // Line-end bytes inside the payload are plain data.
        body_q.push_back(8'h33);
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(hcbd_pkg::CH_LF);
        body_q.push_back(8'hFF);
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(hcbd_pkg::CH_LF);
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(hcbd_pkg::CH_LF);
        drain_mark[body_q.size()] = 1'b1;
        while (body_q.size() < 1570)
        begin
            if ($urandom_range(0, 39) == 0)
                drain_mark[body_q.size()] = 1'b1;
            size = pick_size();
            add_size_line(size);
            add_payload(size);
            body_q.push_back(hcbd_pkg::CH_CR);
            body_q.push_back(hcbd_pkg::CH_LF);
        end
        add_ending();
    endfunction

    // Push the whole body, with random gaps and occasional full drains.
    task automatic send_body();
        int gap;
        for (int i = 0; i < body_q.size(); i++)
        begin
            if ($urandom_range(0, 149) == 0)
                send_calm = !send_calm;
            if (drain_mark.exists(i))
            begin
                push <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            else
            begin
                gap = send_calm ? 0 : pick_gap();
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            push    <= 1'b1;
            in_byte <= body_q[i];
            @(posedge clk);
            while (full)
                @(posedge clk);
            sb.note_byte(body_q[i]);
        end
        push <= 1'b0;
    endtask

    // Main sequence: reset, send the body, wait for the results, report.
    initial
    begin
        sb = new();
        rst_n   <= 1'b0;
        push    <= 1'b0;
        in_byte <= '0;
        build_body();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_body();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: check each transfer and stall pop at random.
    initial
    begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(out_byte, out_valid, status);
            if ($urandom_range(0, 199) == 0)
                recv_calm = !recv_calm;
            if (stall > 0)
                stall--;
            else if (!recv_calm)
                stall = pick_gap();
            pop <= (stall == 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
